/* rtl/core/wrh_pkg.sv */
package wrh_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_EXP_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_RATE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_BITS     = 2'd2;

  localparam logic [15:0] EXP_CHANNELS_RST = 16'd2;
  localparam logic [31:0] EXP_RATE_RST     = 32'd48000;
  localparam logic [15:0] EXP_BITS_RST     = 16'd32;

  // byte offsets only matter below the minimum file length
  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] POS_MAX      = '1;
  localparam logic [POS_W-1:0] MIN_FILE_LEN = 6'd44;
  localparam logic [POS_W-1:0] WAVE_START   = 6'd8;
  localparam logic [POS_W-1:0] HDR_LAST_POS = 6'd11;

  localparam logic [31:0] ID_FMT  = 32'h666D7420;
  localparam logic [31:0] ID_DATA = 32'h64617461;

  localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;
  localparam logic [15:0] FMT_IEEE_FLOAT = 16'd3;

  localparam logic [7:0] TAG_RIFF [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] TAG_WAVE [4] = '{8'h57, 8'h41, 8'h56, 8'h45};

  typedef struct packed {
    logic [15:0] sample_format;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] bits_per_sample;
  } wrh_fmt_t;

  typedef struct packed {
    logic     plausible;
    logic     canonical;
    wrh_fmt_t fmt;
  } wrh_res_t;

endpackage

/* rtl/core/wrh_if.sv */
interface wrh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wrh_out_if;
  logic        valid;
  logic        ready;
  logic        plausible;
  logic        canonical;
  logic [15:0] sample_format;
  logic [15:0] channel_count;
  logic [31:0] rate_hz;
  logic [15:0] bits_per_sample;

  modport source (output valid, output plausible, output canonical, output sample_format,
                  output channel_count, output rate_hz, output bits_per_sample,
                  input ready);
  modport sink   (input valid, input plausible, input canonical, input sample_format,
                  input channel_count, input rate_hz, input bits_per_sample,
                  output ready);
endinterface

/* rtl/core/wav_riff_header_checker_top.sv */
// RIFF/WAVE header checker.
// in_i carries a file one byte per beat, last_byte set on its final byte.
// res_o carries one result beat per file: plausible, canonical and the
// format fields of the last complete fmt chunk.
// cfg_we_i/cfg_idx_i/cfg_data_i write the expected channels (0), rate (1)
// and bits (2); write only while no file is in flight.
// Throughput: one byte per cycle while in_i.ready is high.
// Each result is registered into the output or, while it stalls, the skid.
// Stall: a two-entry output (register plus skid) holds results; in_i.ready
// drops only while both are full.
// Reset: walker state clears, expected values return to 2, 48000 and 32.
// After each final byte the walker returns to its reset state by itself.
module wav_riff_header_checker_top
  import wrh_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  wrh_in_if.sink                in_i,
  wrh_out_if.source             res_o
);

  typedef enum logic [1:0] {PH_FILE, PH_HDR, PH_DATA, PH_PAD} phase_e;

  logic [15:0] exp_ch_q;
  logic [31:0] exp_rate_q;
  logic [15:0] exp_bits_q;

  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             tags_ok_q, tags_ok_d;
  logic [2:0]       hdr_cnt_q, hdr_cnt_d;
  logic [31:0]      id_q, id_d;
  logic [31:0]      size_q, size_d;
  logic [31:0]      left_q, left_d;
  logic [4:0]       off_q, off_d;
  wrh_fmt_t         pend_q, pend_d;
  wrh_fmt_t         comm_q, comm_d;
  logic             fmt_seen_q, fmt_seen_d;
  logic             data_seen_q, data_seen_d;
  logic             done;

  wrh_res_t res_new;
  wrh_res_t out_q, skid_q;
  logic     out_v_q, skid_v_q;
  logic     in_fire, res_v;
  logic [7:0] b;

  assign b       = in_i.data_byte;
  assign in_fire = in_i.valid && in_i.ready;
  assign res_v   = in_fire && in_i.last_byte;
  assign in_i.ready = !skid_v_q;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
    tags_ok_d   = tags_ok_q;
    hdr_cnt_d   = hdr_cnt_q;
    id_d        = id_q;
    size_d      = size_q;
    left_d      = left_q;
    off_d       = off_q;
    pend_d      = pend_q;
    comm_d      = comm_q;
    fmt_seen_d  = fmt_seen_q;
    data_seen_d = data_seen_q;
    done        = 1'b0;
    unique case (phase_q)
      PH_FILE: begin
        if (pos_q < 6'd4 && b != TAG_RIFF[pos_q[1:0]]) tags_ok_d = 1'b0;
        if (pos_q >= WAVE_START && pos_q <= HDR_LAST_POS && b != TAG_WAVE[pos_q[1:0]])
          tags_ok_d = 1'b0;
        if (pos_q >= HDR_LAST_POS) begin
          phase_d   = PH_HDR;
          hdr_cnt_d = '0;
        end
      end
      PH_HDR: begin
        if (!hdr_cnt_q[2]) id_d = {id_q[23:0], b};
        else size_d = {b, size_q[31:8]};
        hdr_cnt_d = hdr_cnt_q + 1'b1;
        if (hdr_cnt_q == 3'd7) begin
          pend_d = '0;
          off_d  = '0;
          if (size_d == '0) done = 1'b1;
          else begin
            phase_d = PH_DATA;
            left_d  = size_d;
          end
        end
      end
      PH_DATA: begin
        if (!off_q[4]) begin
          case (off_q[3:0])
            4'd0:    pend_d.sample_format[7:0]    = b;
            4'd1:    pend_d.sample_format[15:8]   = b;
            4'd2:    pend_d.channel_count[7:0]    = b;
            4'd3:    pend_d.channel_count[15:8]   = b;
            4'd4:    pend_d.rate_hz[7:0]          = b;
            4'd5:    pend_d.rate_hz[15:8]         = b;
            4'd6:    pend_d.rate_hz[23:16]        = b;
            4'd7:    pend_d.rate_hz[31:24]        = b;
            4'd14:   pend_d.bits_per_sample[7:0]  = b;
            4'd15:   pend_d.bits_per_sample[15:8] = b;
            default: ;
          endcase
          off_d = off_q + 1'b1;
        end
        left_d = left_q - 1'b1;
        if (left_q == 32'd1) done = 1'b1;
      end
      PH_PAD: begin
        phase_d   = PH_HDR;
        hdr_cnt_d = '0;
      end
    endcase
    if (done) begin
      if (id_d == ID_FMT && size_d >= FMT_MIN_SIZE) begin
        comm_d     = pend_d;
        fmt_seen_d = 1'b1;
      end else if (id_d == ID_DATA) begin
        data_seen_d = 1'b1;
      end
      phase_d   = size_d[0] ? PH_PAD : PH_HDR;
      hdr_cnt_d = '0;
      left_d    = '0;
    end
  end

  always_comb begin
    res_new.fmt       = comm_d;
    res_new.plausible = tags_ok_d && pos_d >= MIN_FILE_LEN && fmt_seen_d && data_seen_d &&
                        comm_d.channel_count != '0 && comm_d.rate_hz != '0 &&
                        comm_d.bits_per_sample != '0;
    res_new.canonical = res_new.plausible && comm_d.sample_format == FMT_IEEE_FLOAT &&
                        comm_d.channel_count == exp_ch_q && comm_d.rate_hz == exp_rate_q &&
                        comm_d.bits_per_sample == exp_bits_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ch_q   <= EXP_CHANNELS_RST;
      exp_rate_q <= EXP_RATE_RST;
      exp_bits_q <= EXP_BITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXP_CHANNELS: exp_ch_q   <= cfg_data_i[15:0];
        CFG_EXP_RATE:     exp_rate_q <= cfg_data_i;
        CFG_EXP_BITS:     exp_bits_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FILE;
      pos_q       <= '0;
      tags_ok_q   <= 1'b1;
      hdr_cnt_q   <= '0;
      id_q        <= '0;
      size_q      <= '0;
      left_q      <= '0;
      off_q       <= '0;
      pend_q      <= '0;
      comm_q      <= '0;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
    end else if (in_fire) begin
      if (in_i.last_byte) begin
        phase_q     <= PH_FILE;
        pos_q       <= '0;
        tags_ok_q   <= 1'b1;
        hdr_cnt_q   <= '0;
        id_q        <= '0;
        size_q      <= '0;
        left_q      <= '0;
        off_q       <= '0;
        pend_q      <= '0;
        comm_q      <= '0;
        fmt_seen_q  <= 1'b0;
        data_seen_q <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        tags_ok_q   <= tags_ok_d;
        hdr_cnt_q   <= hdr_cnt_d;
        id_q        <= id_d;
        size_q      <= size_d;
        left_q      <= left_d;
        off_q       <= off_d;
        pend_q      <= pend_d;
        comm_q      <= comm_d;
        fmt_seen_q  <= fmt_seen_d;
        data_seen_q <= data_seen_d;
      end
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || res_o.ready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= res_v;
      end
    end else if (res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || res_o.ready) begin
      out_q <= skid_v_q ? skid_q : res_new;
    end else if (res_v) begin
      skid_q <= res_new;
    end
  end

  assign res_o.valid           = out_v_q;
  assign res_o.plausible       = out_q.plausible;
  assign res_o.canonical       = out_q.canonical;
  assign res_o.sample_format   = out_q.fmt.sample_format;
  assign res_o.channel_count   = out_q.fmt.channel_count;
  assign res_o.rate_hz         = out_q.fmt.rate_hz;
  assign res_o.bits_per_sample = out_q.fmt.bits_per_sample;

endmodule

/* dv/tb_wav_riff_header_checker_top.sv */
`timescale 1ns / 100ps

module tb_wav_riff_header_checker_top;
  import wrh_pkg::*;

  typedef enum logic [2:0] {WALK_FILE, WALK_HDR, WALK_DATA, WALK_PAD} walk_e;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [31:0] ID_RIFF = 32'h52494646;
  localparam logic [31:0] ID_WAVE = 32'h57415645;
  localparam logic [31:0] ID_LIST = 32'h4C495354;
  localparam int WDOG_LIMIT = 2000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  wrh_in_if  in_if ();
  wrh_out_if res_if ();

  wav_riff_header_checker_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .res_o      (res_if)
  );

  // predictor state
  logic [15:0] cfg_ch;
  logic [31:0] cfg_rate;
  logic [15:0] cfg_bits;
  logic [31:0] byte_pos;
  logic        tags_ok;
  walk_e       walk_ph;
  logic [31:0] id_sh;
  logic [31:0] size_sh;
  logic [31:0] left_cnt;
  logic [63:0] pend_fmt [2];
  logic [63:0] comm_fmt [2];
  logic        fmt_seen;
  logic        data_seen;

  wrh_res_t   verdict_q [$];
  logic [7:0] file_q [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int n_beats;
  int n_files;
  int n_plausible;
  int n_canonical;
  int n_cfg_writes;
  int mismatches;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic string res_str(input wrh_res_t r);
    return $sformatf("plaus=%0b canon=%0b fmt=%h ch=%h rate=%h bits=%h", r.plausible,
                     r.canonical, r.fmt.sample_format, r.fmt.channel_count, r.fmt.rate_hz,
                     r.fmt.bits_per_sample);
  endfunction

  task automatic clear_walker();
    byte_pos    = '0;
    tags_ok     = 1'b1;
    walk_ph     = WALK_FILE;
    id_sh       = '0;
    size_sh     = '0;
    left_cnt    = '0;
    pend_fmt[0] = '0;
    pend_fmt[1] = '0;
    comm_fmt[0] = '0;
    comm_fmt[1] = '0;
    fmt_seen    = 1'b0;
    data_seen   = 1'b0;
  endtask

  task automatic close_chunk();
    if (id_sh == ID_FMT && size_sh >= FMT_MIN_SIZE) begin
      comm_fmt[0] = pend_fmt[0];
      comm_fmt[1] = pend_fmt[1];
      fmt_seen    = 1'b1;
    end else if (id_sh == ID_DATA) begin
      data_seen = 1'b1;
    end
    walk_ph  = size_sh[0] ? WALK_PAD : WALK_HDR;
    left_cnt = '0;
  endtask

  task automatic walk_byte(input logic [7:0] b);
    logic [31:0] off;
    int          sel;
    int          base;
    case (walk_ph)
      WALK_FILE: begin
        if (byte_pos < 4 && b != TAG_RIFF[byte_pos[1:0]]) tags_ok = 1'b0;
        if (byte_pos >= 8 && byte_pos < 12 && b != TAG_WAVE[byte_pos[1:0]]) tags_ok = 1'b0;
        if (byte_pos >= 11) begin
          walk_ph  = WALK_HDR;
          left_cnt = '0;
        end
      end
      WALK_HDR: begin
        if (left_cnt < 4) id_sh = {id_sh[23:0], b};
        else size_sh = {b, size_sh[31:8]};
        left_cnt++;
        if (left_cnt >= 8) begin
          pend_fmt[0] = '0;
          pend_fmt[1] = '0;
          if (size_sh == 0) begin
            close_chunk();
          end else begin
            walk_ph  = WALK_DATA;
            left_cnt = size_sh;
          end
        end
      end
      WALK_DATA: begin
        off = size_sh - left_cnt;
        if (off < 16) begin
          sel  = int'(off[3]);
          base = int'(off[2:0]) * 8;
          pend_fmt[sel][base +: 8] = pend_fmt[sel][base +: 8] | b;
        end
        left_cnt--;
        if (left_cnt == 0) close_chunk();
      end
      default: begin
        walk_ph  = WALK_HDR;
        left_cnt = '0;
      end
    endcase
    if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic l);
    wrh_res_t r;
    walk_byte(b);
    n_beats++;
    if (l) begin
      r.fmt.sample_format   = comm_fmt[0][15:0];
      r.fmt.channel_count   = comm_fmt[0][31:16];
      r.fmt.rate_hz         = comm_fmt[0][63:32];
      r.fmt.bits_per_sample = comm_fmt[1][63:48];
      r.plausible = tags_ok && byte_pos >= MIN_FILE_LEN && fmt_seen && data_seen &&
                    r.fmt.channel_count != 0 && r.fmt.rate_hz != 0 &&
                    r.fmt.bits_per_sample != 0;
      r.canonical = r.plausible && r.fmt.sample_format == FMT_IEEE_FLOAT &&
                    r.fmt.channel_count == cfg_ch && r.fmt.rate_hz == cfg_rate &&
                    r.fmt.bits_per_sample == cfg_bits;
      verdict_q.push_back(r);
      n_files++;
      if (r.plausible) n_plausible++;
      if (r.canonical) n_canonical++;
      clear_walker();
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_beat(b, l);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_beat(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  task automatic wait_verdicts_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk_i);
    case (idx)
      CFG_EXP_CHANNELS: cfg_ch = d[15:0];
      CFG_EXP_RATE:     cfg_rate = d[31:0];
      CFG_EXP_BITS:     cfg_bits = d[15:0];
      default: ;
    endcase
    n_cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [15:0] ch, input logic [31:0] rate,
                             input logic [15:0] bits);
    wait_verdicts_drained();
    cfg_write(CFG_EXP_CHANNELS, {16'($urandom), ch});
    cfg_write(CFG_EXP_RATE, rate);
    cfg_write(CFG_EXP_BITS, {16'($urandom), bits});
  endtask

  task automatic put_u16(input logic [15:0] v);
    file_q.push_back(v[7:0]);
    file_q.push_back(v[15:8]);
  endtask

  task automatic put_u32(input logic [31:0] v);
    put_u16(v[15:0]);
    put_u16(v[31:16]);
  endtask

  task automatic put_id(input logic [31:0] v);
    file_q.push_back(v[31:24]);
    file_q.push_back(v[23:16]);
    file_q.push_back(v[15:8]);
    file_q.push_back(v[7:0]);
  endtask

  task automatic put_head();
    put_id(ID_RIFF);
    put_u32($urandom);
    put_id(ID_WAVE);
  endtask

  task automatic put_fmt(input logic [31:0] size, input logic [15:0] f, input logic [15:0] ch,
                         input logic [31:0] rate, input logic [15:0] bits);
    logic [127:0] body;
    body = {bits, 16'($urandom), 32'($urandom), rate, ch, f};
    put_id(ID_FMT);
    put_u32(size);
    for (int i = 0; i < size; i++) file_q.push_back(i < 16 ? body[i*8 +: 8] : 8'($urandom));
    if (size[0]) file_q.push_back(8'($urandom));
  endtask

  task automatic put_blob(input logic [31:0] id, input logic [31:0] size);
    put_id(id);
    put_u32(size);
    repeat (size) file_q.push_back(8'($urandom));
    if (size[0]) file_q.push_back(8'($urandom));
  endtask

  // mostly well-formed files with random content; some noise, corrupted headers and cut files
  task automatic make_random_file();
    int          kind;
    int          nchunks;
    int          pick;
    int          cut;
    logic [15:0] f;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [31:0] rate;
    logic [31:0] sz;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(16, 1)) file_q.push_back(8'($urandom));
      return;
    end
    put_head();
    if (kind < 22) file_q[$urandom_range(11)] ^= 8'($urandom_range(255, 1));
    nchunks = $urandom_range(3, 1);
    for (int c = 0; c < nchunks; c++) begin
      pick = $urandom_range(9);
      if (c == 0 && $urandom_range(99) < 70) pick = 0;
      if (c == nchunks - 1 && $urandom_range(99) < 70) pick = 5;
      if (pick < 4) begin
        f    = ($urandom_range(99) < 60) ? FMT_IEEE_FLOAT :
               ($urandom_range(1) ? 16'd1 : 16'($urandom));
        ch   = ($urandom_range(99) < 70) ? cfg_ch : 16'($urandom_range(3));
        rate = ($urandom_range(99) < 70) ? cfg_rate : 32'($urandom);
        bits = ($urandom_range(99) < 70) ? cfg_bits : 16'($urandom);
        sz   = ($urandom_range(99) < 75) ? FMT_MIN_SIZE : 32'($urandom_range(20));
        put_fmt(sz, f, ch, rate, bits);
      end else if (pick < 7) begin
        put_blob(ID_DATA, $urandom_range(6));
      end else begin
        put_blob($urandom_range(1) ? ID_LIST : 32'($urandom), $urandom_range(5));
      end
    end
    cut = $urandom_range(99);
    if (cut < 6) begin
      put_id($urandom);
      put_u32(32'($urandom) | 32'h8000_0000);
      repeat ($urandom_range(6)) file_q.push_back(8'($urandom));
    end else if (cut < 20) begin
      repeat ($urandom_range(file_q.size() - 1, 1)) void'(file_q.pop_back());
    end
  endtask

  task automatic test_directed_files();
    file_q.push_back(8'h00);
    send_file();
    file_q.push_back(8'hFF);
    send_file();
    // minimal canonical file, zero-size data chunk
    put_head();
    put_fmt(FMT_MIN_SIZE, FMT_IEEE_FLOAT, EXP_CHANNELS_RST, EXP_RATE_RST, EXP_BITS_RST);
    put_blob(ID_DATA, 0);
    send_file();
    // bad RIFF tag
    put_head();
    file_q[0] = 8'h72;
    put_fmt(16, FMT_IEEE_FLOAT, 16'd2, 32'd48000, 16'd32);
    put_blob(ID_DATA, 0);
    send_file();
    // bad WAVE tag
    put_head();
    file_q[11] = 8'h65;
    put_fmt(16, FMT_IEEE_FLOAT, 16'd2, 32'd48000, 16'd32);
    put_blob(ID_DATA, 0);
    send_file();
    // no fmt chunk
    put_head();
    put_blob(ID_LIST, 1);
    put_blob(ID_DATA, 0);
    send_file();
    // fmt one byte short, padded
    put_head();
    put_fmt(15, FMT_IEEE_FLOAT, 16'd2, 32'd48000, 16'd32);
    put_blob(ID_DATA, 0);
    send_file();
    // padded integer fmt overwritten by a float one; long enough to pass any offset limit
    put_head();
    put_fmt(17, 16'd1, 16'd6, 32'd96000, 16'd24);
    put_fmt(16, FMT_IEEE_FLOAT, 16'd2, 32'd48000, 16'd32);
    put_blob(ID_DATA, 0);
    send_file();
    // file ends inside the fmt chunk
    put_head();
    put_blob(ID_DATA, 0);
    put_fmt(16, FMT_IEEE_FLOAT, 16'd2, 32'd48000, 16'd32);
    repeat (6) void'(file_q.pop_back());
    send_file();
  endtask

  task automatic test_config_extremes();
    load_config(16'h0000, 32'h0000_0000, 16'h0000);
    cfg_write(CFG_IDX_SPARE, $urandom);
    put_head();
    put_fmt(16, FMT_IEEE_FLOAT, 16'd1, 32'd1, 16'd1);
    put_blob(ID_DATA, 0);
    send_file();
    load_config(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_head();
    put_fmt(16, FMT_IEEE_FLOAT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_blob(ID_DATA, 0);
    send_file();
  endtask

  // long result hold-off with the input still busy, then a full drain
  task automatic test_backpressure();
    hold_cycles = 80;
    repeat (12) begin
      file_q.push_back(8'($urandom));
      send_file();
    end
    wait_verdicts_drained();
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct);
    int          beats0;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [31:0] rate;
    beats0 = n_beats;
    if ($urandom_range(1)) begin
      ch = 16'($urandom_range(8, 1));
      case ($urandom_range(3))
        0:       rate = 32'd44100;
        1:       rate = 32'd48000;
        2:       rate = 32'd96000;
        default: rate = $urandom;
      endcase
      bits = ($urandom_range(1)) ? 16'd32 : 16'd16 + 16'($urandom_range(1)) * 16'd8;
    end else begin
      ch   = 16'($urandom);
      rate = $urandom;
      bits = 16'($urandom);
    end
    load_config(ch, rate, bits);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (n_beats - beats0 < 20) begin
      make_random_file();
      send_file();
    end
    wait_verdicts_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    wrh_res_t want;
    wrh_res_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.plausible           = res_if.plausible;
        got.canonical           = res_if.canonical;
        got.fmt.sample_format   = res_if.sample_format;
        got.fmt.channel_count   = res_if.channel_count;
        got.fmt.rate_hz         = res_if.rate_hz;
        got.fmt.bits_per_sample = res_if.bits_per_sample;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %s", res_str(got));
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch\n  expected %s\n  actual   %s", res_str(want),
                       res_str(got));
          end
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", WDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_EXP_CHANNELS;
    cfg_data        <= '0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    cfg_ch          = EXP_CHANNELS_RST;
    cfg_rate        = EXP_RATE_RST;
    cfg_bits        = EXP_BITS_RST;
    clear_walker();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_cycles     = 0;
    n_beats         = 0;
    n_files         = 0;
    n_plausible     = 0;
    n_canonical     = 0;
    n_cfg_writes    = 0;
    mismatches      = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_files();
    test_config_extremes();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(62, 0);
    test_random_phase(0, 62);
    test_random_phase(12, 12);

    wait_verdicts_drained();
    repeat (6) @(posedge clk_i);
    mismatches += verdict_q.size();
    $display("%0d files in %0d byte beats: %0d plausible, %0d canonical", n_files, n_beats,
             n_plausible, n_canonical);
    $display("%0d config writes incl. all-zero and all-ones, %0d mismatches", n_cfg_writes,
             mismatches);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
